// ----- sv/name_cache_lru_fifo_core_assert.svh -----
// Assertion macros used by the name cache datapath (ncl_dp).
`ifndef NAME_CACHE_LRU_FIFO_CORE_ASSERT_SVH
`define NAME_CACHE_LRU_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NCL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("name cache: same-cycle check failed");

// Next-cycle implication.
`define NCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("name cache: next-cycle check failed");

`endif

// ----- sv/ncl_pkg.sv -----
// Package: types, codes and defaults for the name cache.
`default_nettype none

package ncl_pkg;

  localparam int NCL_CAPACITY = 16;
  localparam int NCL_KEY_BITS = 64;
  localparam int KEY_W        = 64;
  localparam int VALUE_W      = 24;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic MODE_FIFO  = 1'b0;
  localparam logic MODE_LRU   = 1'b1;

  typedef struct packed {
    logic               action;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_in;
  } ncl_in_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic               evicted;
  } ncl_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;   // capture the accepted word
    logic cmp;     // compare cycle
    logic update;  // write-back / result cycle
  } ncl_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RSP
  } ncl_state_t;

endpackage

`default_nettype wire

// ----- sv/ncl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ncl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/ncl_ctrl.sv -----
// Controller: sequences compare and update cycles for each word.
`default_nettype none

module ncl_ctrl import ncl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output ncl_cmd_t  cmd,
  output logic      out_valid
);

  ncl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    cmd        = '0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.latch = start;
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        busy      = 1'b1;
        cmd.cmp   = 1'b1;
        state_nxt = ST_RSP;
      end
      ST_RSP: begin
        cmd.update = 1'b1;
        out_valid  = 1'b1;
        // next word may enter while this one is written back
        cmd.latch  = start;
        state_nxt  = start ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/ncl_dp.sv -----
// Datapath: key CAM lanes, age ranks, value RAM and result formatting.
`default_nettype none
`include "name_cache_lru_fifo_core_assert.svh"

module ncl_dp import ncl_pkg::*; #(
  parameter int CAPACITY = NCL_CAPACITY,
  parameter int KEY_BITS = NCL_KEY_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ncl_cmd_t cmd,
  input  wire ncl_in_t  in_data,
  input  wire logic     mode,
  output ncl_out_t      out_data
);

  localparam int RANK_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(CAPACITY - 1);

  // latched word
  logic                act_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_W-1:0]  val_r;

  // per-entry state
  logic [KEY_BITS-1:0] keys_r  [CAPACITY];
  logic [RANK_W-1:0]   rank_r  [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [CNT_W-1:0]    cnt_r;

  // compare results
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] victim_vec;
  logic [RANK_W-1:0]   hit_idx;
  logic [RANK_W-1:0]   hit_rank;
  logic [RANK_W-1:0]   victim_idx;
  logic                full;

  logic                hit_r;
  logic                full_r;
  logic [RANK_W-1:0]   hit_idx_r;
  logic [RANK_W-1:0]   hit_rank_r;
  logic [RANK_W-1:0]   slot_r;

  logic                ins_new;
  logic                promote;
  logic [VALUE_W-1:0]  rd_value;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_data.action;
      key_r <= in_data.key[KEY_BITS-1:0];
      val_r <= in_data.value_in;
    end
  end

  assign full = (cnt_r == CNT_W'(CAPACITY));

  // Valid slots are always 0..cnt-1 and ranks a permutation of them,
  // so the eviction victim is the one lane holding the oldest rank.
  always_comb begin
    hit_idx    = '0;
    hit_rank   = '0;
    victim_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i]  = valid_r[i] && (keys_r[i] == key_r);
      victim_vec[i] = valid_r[i] && (rank_r[i] == RANK_OLDEST);
      if (match_vec[i]) begin
        hit_idx  = hit_idx | RANK_W'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (victim_vec[i]) begin
        victim_idx = victim_idx | RANK_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_r      <= |match_vec;
      full_r     <= full;
      hit_idx_r  <= hit_idx;
      hit_rank_r <= hit_rank;
      slot_r     <= full ? victim_idx : cnt_r[RANK_W-1:0];
    end
  end

  assign ins_new = (act_r == ACT_INSERT) && !hit_r;
  assign promote = hit_r && (mode == MODE_LRU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update) begin
      if (ins_new && !full_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (promote) begin
          if (RANK_W'(i) == hit_idx_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end else if (ins_new) begin
          if (RANK_W'(i) == slot_r) begin
            rank_r[i]  <= '0;
            valid_r[i] <= 1'b1;
          end else if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.update && ins_new && (RANK_W'(i) == slot_r)) begin
        keys_r[i] <= key_r;
      end
    end
  end

  ncl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk     (clk),
    .we      (cmd.update && ins_new),
    .waddr   (slot_r),
    .wdata   (val_r),
    .raddr   (hit_idx),
    .rdata_r (rd_value)
  );

  always_comb begin
    out_data.hit       = hit_r;
    out_data.value_out = hit_r ? rd_value : '0;
    out_data.evicted   = ins_new && full_r;
  end

  `NCL_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `NCL_ASSERT_IMPLIES(a_key_unique, cmd.cmp, $onehot0(match_vec))
  `NCL_ASSERT_IMPLIES(a_victim_one, cmd.cmp && full, $onehot(victim_vec))
  `NCL_ASSERT_NEXT(a_cnt_step, cmd.update && ins_new && !full_r,
                   cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- sv/name_cache_lru_fifo_core.sv -----
// Top level of the fully associative name cache with LRU/FIFO replacement.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------
//  input    | start / busy                    | in_data  (action, key, value_in)
//  result   | out_valid (one-cycle strobe)    | out_data (hit, value_out, evicted)
//  config   | psel penable pwrite pready      | paddr, pwdata, prdata
//
// Sequence: a word accepted from idle or the result state is compared
// against all key lanes in the compare state; its result is strobed in the
// result state while ranks, keys and the value RAM are written back. A new
// word can be accepted as the result state ends, so it overlaps the write-back
// of the previous word, but not while busy in the compare state.
// Reset: cache empty, replacement mode LRU; no clearing pass is needed.
// The receiver cannot stall; the result is valid for its strobe cycle only.
`default_nettype none

module name_cache_lru_fifo_core import ncl_pkg::*; #(
  parameter int CAPACITY = NCL_CAPACITY,
  parameter int KEY_BITS = NCL_KEY_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input words
  input  wire logic                  start,
  output logic                       busy,
  input  wire ncl_in_t               in_data,
  // results
  output logic                       out_valid,
  output ncl_out_t                   out_data,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  ncl_cmd_t cmd;
  logic     mode_r;

  // Single register (replacement_mode) at byte address 0; the low address
  // bits are the byte offset within that word.
  assign pready = 1'b1;
  assign prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LRU;
    end else if (psel && penable && pwrite && pready) begin
      mode_r <= pwdata[0];
    end
  end

  ncl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  ncl_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .mode     (mode_r),
    .out_data (out_data)
  );

  // paddr only carries the byte offset of the single register
  logic unused_paddr;
  assign unused_paddr = ^paddr;

endmodule

`default_nettype wire
